FILE: rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: shared types and constants of the potential field force summer
// Field widths, fixed-point constants and reset values, state and register
// codes, and the sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int RANGE_W     = 16;
	localparam int ANGLE_W     = 16;
	localparam int POS_W       = 24;
	localparam int GAIN_W      = 16;
	localparam int DIST_W      = 16;
	localparam int FORCE_W     = 48;
	localparam int CFG_DATA_W  = 24;

	localparam int ANGLE_LSB   = RANGE_W;
	localparam int RX_LSB      = ANGLE_LSB + ANGLE_W;
	localparam int RY_LSB      = RX_LSB + POS_W;
	localparam int S_TDATA_W   = RY_LSB + POS_W;
	localparam int M_TDATA_W   = 2 * FORCE_W;

	// Repulsive magnitude and divider geometry
	localparam int NUM_SHIFT   = 24;
	localparam int FMAG_W      = GAIN_W + NUM_SHIFT;
	localparam int DEN_W       = 2 * DIST_W;
	localparam int DIV_STEPS   = FMAG_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int SUM_EXT_W   = FORCE_W + 1;
	localparam int DIFF_W      = POS_W + 1;
	localparam int ATTR_W      = GAIN_W + 1 + DIFF_W;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

	localparam logic [DIST_W-1:0]  RST_SAFE_DISTANCE   = 16'd256;
	localparam logic [DIST_W-1:0]  RST_MARGIN          = 16'd13;
	localparam logic [DIST_W-1:0]  RST_INFLUENCE_LIMIT = 16'd512;
	localparam logic [GAIN_W-1:0]  RST_REPULSE_GAIN    = 16'd128;
	localparam logic [GAIN_W-1:0]  RST_ATTRACT_GAIN    = 16'd2560;

	localparam longint PI_Q30 = 64'sd3373259426;

	typedef enum logic [2:0] {
		REG_SAFE_DISTANCE,
		REG_MARGIN,
		REG_INFLUENCE_LIMIT,
		REG_REPULSE_GAIN,
		REG_ATTRACT_GAIN,
		REG_GOAL_X,
		REG_GOAL_Y
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_MULGO,
		ST_MUL,
		ST_ADD_REP,
		ST_ADD_ATT,
		ST_EMIT
	} state_t;

	// Quarter-wave sine magnitude from a Q30 angle, Taylor series to x^21.
	function automatic longint sine_mag(input longint x, input int bits);
		longint s;
		longint t;
		longint amp;
		longint v;
		s = x;
		t = x;
		t = ((((t * x) >>> 30) * x) >>> 30) / 6;   s = s - t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 20;  s = s + t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 42;  s = s - t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 72;  s = s + t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 110; s = s - t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 156; s = s + t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 210; s = s - t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 272; s = s + t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 342; s = s - t;
		t = ((((t * x) >>> 30) * x) >>> 30) / 420; s = s + t;
		if (s < 0) begin
			s = 0;
		end
		amp = longint'(1) <<< (bits - 1);
		v = (s * amp + (longint'(1) <<< 29)) >>> 30;
		if (v > amp - 1) begin
			v = amp - 1;
		end
		return v;
	endfunction

endpackage

FILE: rtl/pfs_div.sv
// ----------------------------------------------------------------------------
// pfs_div: radix-4 restoring divider
// Unsigned quotient of the repulsive numerator by the squared distance,
// two quotient bits per cycle, done pulses with the quotient in place.
// ----------------------------------------------------------------------------
module pfs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfs_pkg::FMAG_W-1:0]    num,
	input  logic [pfs_pkg::DEN_W-1:0]     den,
	output logic [pfs_pkg::FMAG_W-1:0]    quot,
	output logic                          done
);

	localparam int FW = pfs_pkg::FMAG_W;
	localparam int DW = pfs_pkg::DEN_W;

	logic                           busy_q;
	logic                           done_q;
	logic [pfs_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [DW-1:0]                  rem_q;
	logic [DW-1:0]                  den_q;
	logic [FW-1:0]                  work_q;

	logic [DW:0]   trial1, diff1, trial2, diff2;
	logic          ge1, ge2;
	logic [DW-1:0] rem1, rem2;
	logic [FW-1:0] work1, work2;

	always_comb begin
		trial1 = {rem_q, work_q[FW-1]};
		diff1  = trial1 - {1'b0, den_q};
		ge1    = trial1 >= {1'b0, den_q};
		rem1   = ge1 ? diff1[DW-1:0] : trial1[DW-1:0];
		work1  = {work_q[FW-2:0], ge1};
		trial2 = {rem1, work1[FW-1]};
		diff2  = trial2 - {1'b0, den_q};
		ge2    = trial2 >= {1'b0, den_q};
		rem2   = ge2 ? diff2[DW-1:0] : trial2[DW-1:0];
		work2  = {work1[FW-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pfs_pkg::DIV_CNT_W'(pfs_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			work_q <= num;
		end else if (busy_q) begin
			rem_q  <= rem2;
			work_q <= work2;
		end
	end

	assign quot = work_q;
	assign done = done_q;

endmodule

FILE: rtl/pfs_smul.sv
// ----------------------------------------------------------------------------
// pfs_smul: bit-serial scaling multiplier
// Computes floor(f * coef / 2^COEF_W) one coefficient bit per cycle with a
// right-shifting accumulator.
// ----------------------------------------------------------------------------
module pfs_smul #(
	parameter int COEF_W = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pfs_pkg::FMAG_W-1:0]  f,
	input  logic [COEF_W-1:0]           coef,
	output logic [pfs_pkg::FMAG_W-1:0]  prod,
	output logic                        done
);

	localparam int FW    = pfs_pkg::FMAG_W;
	localparam int CNT_W = $clog2(COEF_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FW-1:0]     acc_q;
	logic [FW-1:0]     f_q;
	logic [COEF_W-1:0] coef_q;
	logic [FW:0]       sum;

	assign sum = {1'b0, acc_q} + (coef_q[0] ? {1'b0, f_q} : {(FW + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COEF_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			f_q    <= f;
			coef_q <= coef;
		end else if (busy_q) begin
			acc_q  <= sum[FW:1];
			coef_q <= coef_q >> 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

FILE: rtl/potential_field_force_sum_core.sv
// ----------------------------------------------------------------------------
// potential_field_force_sum_core: laser scan potential field force summer
// Accumulates per-ray repulsive forces and adds the goal attraction on the
// last ray of a scan.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   one ray per word: range, bearing, robot position; tlast ends a scan.
//   m_*   one word per scan: force_x, force_y in tdata, clip flag in tuser.
//   cfg_* register writes, always ready; write only while the block is idle.
// Timing:
//   A ray in the repulsive zones is held from accept to the next accept while
//   it passes the two-bit-per-cycle divider and then the bit-serial sine
//   scaling multipliers; no new ray is taken meanwhile.
//   A ray with no division (outside the zones or zero margin) skips the divider.
//   The last ray of a scan also passes the attraction add and the emit state;
//   its result is valid on m_tvalid once the result register is loaded.
// Stalls and reset:
//   The result register holds a word until m_tready; rays of the next scan
//   keep flowing, and only the next last ray waits for the register to free.
//   Reset loads register defaults, clears the sums and drops m_tvalid.
// ----------------------------------------------------------------------------
module potential_field_force_sum_core #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int SINE_BITS        = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ray_range, ray_angle, robot_x, robot_y
	input  logic [pfs_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// force_x, force_y
	output logic [pfs_pkg::M_TDATA_W-1:0]     m_tdata,
	// saturated
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  pfs_pkg::cfg_reg_t                 cfg_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
	localparam int COEF_W    = SINE_BITS - 1;
	localparam int IPROD_W   = pfs_pkg::ANGLE_W + IDX_W + 1;
	localparam int FW        = pfs_pkg::FMAG_W;
	localparam int SW        = pfs_pkg::SUM_EXT_W;
	localparam int OW        = pfs_pkg::FORCE_W;
	localparam int AW        = pfs_pkg::ATTR_W;
	localparam logic [OW-1:0] FORCE_MAX = {1'b0, {(OW - 1){1'b1}}};
	localparam logic [OW-1:0] FORCE_MIN = {1'b1, {(OW - 1){1'b0}}};

	logic signed [SINE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint M  = 4 * k;
		localparam longint Q  = M / SINE_TABLE_DEPTH;
		localparam longint R0 = M % SINE_TABLE_DEPTH;
		localparam longint R  = (Q % 2 == 1) ? SINE_TABLE_DEPTH - R0 : R0;
		localparam longint X  = (pfs_pkg::PI_Q30 * R) / (2 * SINE_TABLE_DEPTH);
		localparam longint V  = pfs_pkg::sine_mag(X, SINE_BITS);
		localparam longint E  = (Q >= 2) ? -V : V;
		assign sine_rom[k] = SINE_BITS'(E);
	end

	pfs_pkg::state_t state_q, state_d;

	// configuration
	logic [pfs_pkg::DIST_W-1:0] safe_distance_q, margin_q, influence_limit_q;
	logic [pfs_pkg::GAIN_W-1:0] repulse_gain_q, attract_gain_q;
	logic [pfs_pkg::POS_W-1:0]  goal_x_q, goal_y_q;

	// ray
	logic [pfs_pkg::RANGE_W-1:0] range_q;
	logic [pfs_pkg::ANGLE_W-1:0] angle_q;
	logic [pfs_pkg::POS_W-1:0]   robot_x_q, robot_y_q;
	logic                        last_q;

	logic [pfs_pkg::DEN_W-1:0]   den_q;
	logic [FW-1:0]               num_q;
	logic                        hit_q;
	logic signed [AW-1:0]        attr_x_q, attr_y_q;
	logic signed [SINE_BITS-1:0] cos_q, sin_q;
	logic [FW-1:0]               f_q;

	logic [OW-1:0] sum_x_q, sum_y_q;
	logic          clip_q;

	logic              out_valid_q;
	logic [OW-1:0]     out_x_q, out_y_q;
	logic              out_clip_q;

	logic accept, div_start, div_done, mul_start, mul_x_done, mul_y_done, load_out;
	logic [FW-1:0] div_quot, prod_x, prod_y;

	// ------------------------------------------------------------------------
	// FSM
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			pfs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pfs_pkg::ST_PREP;
				end
			end
			pfs_pkg::ST_PREP: begin
				state_d = pfs_pkg::ST_START;
			end
			pfs_pkg::ST_START: begin
				if (hit_q && den_q != '0) begin
					div_start = 1'b1;
					state_d   = pfs_pkg::ST_DIV;
				end else begin
					state_d = pfs_pkg::ST_MULGO;
				end
			end
			pfs_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = pfs_pkg::ST_MULGO;
				end
			end
			pfs_pkg::ST_MULGO: begin
				mul_start = 1'b1;
				state_d   = pfs_pkg::ST_MUL;
			end
			pfs_pkg::ST_MUL: begin
				if (mul_x_done && mul_y_done) begin
					state_d = pfs_pkg::ST_ADD_REP;
				end
			end
			pfs_pkg::ST_ADD_REP: begin
				state_d = last_q ? pfs_pkg::ST_ADD_ATT : pfs_pkg::ST_IDLE;
			end
			pfs_pkg::ST_ADD_ATT: begin
				state_d = pfs_pkg::ST_EMIT;
			end
			pfs_pkg::ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = pfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfs_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_distance_q   <= pfs_pkg::RST_SAFE_DISTANCE;
			margin_q          <= pfs_pkg::RST_MARGIN;
			influence_limit_q <= pfs_pkg::RST_INFLUENCE_LIMIT;
			repulse_gain_q    <= pfs_pkg::RST_REPULSE_GAIN;
			attract_gain_q    <= pfs_pkg::RST_ATTRACT_GAIN;
			goal_x_q          <= '0;
			goal_y_q          <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pfs_pkg::REG_SAFE_DISTANCE:   safe_distance_q   <= cfg_data[pfs_pkg::DIST_W-1:0];
				pfs_pkg::REG_MARGIN:          margin_q          <= cfg_data[pfs_pkg::DIST_W-1:0];
				pfs_pkg::REG_INFLUENCE_LIMIT: influence_limit_q <= cfg_data[pfs_pkg::DIST_W-1:0];
				pfs_pkg::REG_REPULSE_GAIN:    repulse_gain_q    <= cfg_data[pfs_pkg::GAIN_W-1:0];
				pfs_pkg::REG_ATTRACT_GAIN:    attract_gain_q    <= cfg_data[pfs_pkg::GAIN_W-1:0];
				pfs_pkg::REG_GOAL_X:          goal_x_q          <= cfg_data[pfs_pkg::POS_W-1:0];
				pfs_pkg::REG_GOAL_Y:          goal_y_q          <= cfg_data[pfs_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// zone, divisor, attraction and sine lookup
	// ------------------------------------------------------------------------
	logic [pfs_pkg::DIST_W:0]    near_lim;
	logic                        near_zone, mid_zone;
	logic [pfs_pkg::DIST_W-1:0]  divisor;
	logic signed [pfs_pkg::DIFF_W-1:0] dx, dy;
	logic signed [pfs_pkg::GAIN_W:0]   gain_s;
	logic signed [AW-1:0]        attr_x, attr_y;
	logic [pfs_pkg::ANGLE_W-1:0] angle_c;
	logic [IPROD_W-1:0]          si_prod, ci_prod;
	logic [IDX_W-1:0]            rd_idx;

	always_comb begin
		near_lim  = {1'b0, safe_distance_q} + {1'b0, margin_q};
		mid_zone  = ({1'b0, range_q} > near_lim) && (range_q < influence_limit_q);
		near_zone = {1'b0, range_q} <= near_lim;
		divisor   = mid_zone ? range_q - safe_distance_q : margin_q;
		dx        = $signed({goal_x_q[pfs_pkg::POS_W-1], goal_x_q})
		          - $signed({robot_x_q[pfs_pkg::POS_W-1], robot_x_q});
		dy        = $signed({goal_y_q[pfs_pkg::POS_W-1], goal_y_q})
		          - $signed({robot_y_q[pfs_pkg::POS_W-1], robot_y_q});
		gain_s    = $signed({1'b0, attract_gain_q});
		attr_x    = gain_s * dx;
		attr_y    = gain_s * dy;
		angle_c   = angle_q + pfs_pkg::QUARTER_TURN;
		si_prod   = IPROD_W'(angle_q) * IPROD_W'(SINE_TABLE_DEPTH);
		ci_prod   = IPROD_W'(angle_c) * IPROD_W'(SINE_TABLE_DEPTH);
		rd_idx    = (state_q == pfs_pkg::ST_PREP) ? ci_prod[pfs_pkg::ANGLE_W +: IDX_W]
		                                          : si_prod[pfs_pkg::ANGLE_W +: IDX_W];
	end

	// ------------------------------------------------------------------------
	// force magnitude and component scaling
	// ------------------------------------------------------------------------
	pfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	logic [SINE_BITS-1:0] cos_abs, sin_abs;

	assign cos_abs = cos_q[SINE_BITS-1] ? $unsigned(-cos_q) : $unsigned(cos_q);
	assign sin_abs = sin_q[SINE_BITS-1] ? $unsigned(-sin_q) : $unsigned(sin_q);

	pfs_smul #(.COEF_W(COEF_W)) u_smul_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.f      (f_q),
		.coef   (cos_abs[COEF_W-1:0]),
		.prod   (prod_x),
		.done   (mul_x_done)
	);

	pfs_smul #(.COEF_W(COEF_W)) u_smul_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.f      (f_q),
		.coef   (sin_abs[COEF_W-1:0]),
		.prod   (prod_y),
		.done   (mul_y_done)
	);

	// ------------------------------------------------------------------------
	// saturating sums
	// ------------------------------------------------------------------------
	logic [SW-1:0] px_ext, py_ext, add_x, add_y, ext_x, ext_y;
	logic          ovf_x, ovf_y;
	logic [OW-1:0] sat_x, sat_y;

	always_comb begin
		px_ext = {{(SW - FW){1'b0}}, prod_x};
		py_ext = {{(SW - FW){1'b0}}, prod_y};
		if (state_q == pfs_pkg::ST_ADD_REP) begin
			add_x = cos_q[SINE_BITS-1] ? px_ext : SW'(0) - px_ext;
			add_y = sin_q[SINE_BITS-1] ? py_ext : SW'(0) - py_ext;
		end else begin
			add_x = {{(SW - AW){attr_x_q[AW-1]}}, attr_x_q};
			add_y = {{(SW - AW){attr_y_q[AW-1]}}, attr_y_q};
		end
		ext_x = {sum_x_q[OW-1], sum_x_q} + add_x;
		ext_y = {sum_y_q[OW-1], sum_y_q} + add_y;
		ovf_x = ext_x[OW] ^ ext_x[OW-1];
		ovf_y = ext_y[OW] ^ ext_y[OW-1];
		sat_x = ovf_x ? (ext_x[OW] ? FORCE_MIN : FORCE_MAX) : ext_x[OW-1:0];
		sat_y = ovf_y ? (ext_y[OW] ? FORCE_MIN : FORCE_MAX) : ext_y[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			clip_q  <= 1'b0;
		end else begin
			priority if (load_out) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				clip_q  <= 1'b0;
			end else if (state_q == pfs_pkg::ST_ADD_REP || state_q == pfs_pkg::ST_ADD_ATT) begin
				sum_x_q <= sat_x;
				sum_y_q <= sat_y;
				clip_q  <= clip_q | ovf_x | ovf_y;
			end else if (state_q == pfs_pkg::ST_START && hit_q && den_q == '0 && num_q != '0) begin
				clip_q  <= 1'b1;
			end else begin
				clip_q  <= clip_q;
			end
		end
	end

	// ------------------------------------------------------------------------
	// ray datapath
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			range_q   <= s_tdata[0 +: pfs_pkg::RANGE_W];
			angle_q   <= s_tdata[pfs_pkg::ANGLE_LSB +: pfs_pkg::ANGLE_W];
			robot_x_q <= s_tdata[pfs_pkg::RX_LSB +: pfs_pkg::POS_W];
			robot_y_q <= s_tdata[pfs_pkg::RY_LSB +: pfs_pkg::POS_W];
			last_q    <= s_tlast;
		end
		if (state_q == pfs_pkg::ST_PREP) begin
			den_q    <= divisor * divisor;
			num_q    <= {repulse_gain_q, {pfs_pkg::NUM_SHIFT{1'b0}}};
			hit_q    <= near_zone || mid_zone;
			attr_x_q <= attr_x;
			attr_y_q <= attr_y;
			cos_q    <= sine_rom[rd_idx];
		end
		if (state_q == pfs_pkg::ST_START) begin
			sin_q <= sine_rom[rd_idx];
			if (!hit_q || num_q == '0) begin
				f_q <= '0;
			end else if (den_q == '0) begin
				f_q <= {FW{1'b1}};
			end
		end
		if (state_q == pfs_pkg::ST_DIV && div_done) begin
			f_q <= div_quot;
		end
	end

	// ------------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q    <= sum_x_q;
			out_y_q    <= sum_y_q;
			out_clip_q <= clip_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_clip_q;

endmodule

FILE: rtl/pfs_chk.sv
// ----------------------------------------------------------------------------
// pfs_chk: port checker for the potential field force summer
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module pfs_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pfs_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ray word taken while previous ray in flight");

	a_no_result_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
		else $error("result word raised by a ray that does not end the scan");

endmodule

bind potential_field_force_sum_core pfs_chk u_pfs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
